>>> design/lcr_pkg.sv
// ============================================================================
// Link command recognizer package
// Shared constants, types and digit conversion helpers for the link command
// recognizer.
// ============================================================================
package lcr_pkg;

    // Command buffer geometry.
    localparam int BUFFER_CHARS = 14;
    localparam int CNT_W        = $clog2(BUFFER_CHARS + 1);
    localparam int IDX_W        = $clog2(BUFFER_CHARS);

    // Special characters.
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Command words, first character in the high byte.
    localparam logic [31:0] CMD_CONN   = "CONN";
    localparam logic [31:0] CMD_LOST   = "LOST";
    localparam logic [39:0] CMD_TIME   = "TIME:";
    localparam logic [39:0] CMD_DATE   = "DATE:";
    localparam logic [39:0] CMD_NOTIFY = "ANCS8";
    localparam logic [47:0] CMD_UPDATE = "UPDATE";

    // Required fill counts for each command.
    localparam logic [CNT_W-1:0] LEN_SHORT  = CNT_W'(4);
    localparam logic [CNT_W-1:0] LEN_TIME   = CNT_W'(11);
    localparam logic [CNT_W-1:0] LEN_DATE   = CNT_W'(14);
    localparam logic [CNT_W-1:0] LEN_NOTIFY = CNT_W'(13);
    localparam logic [CNT_W-1:0] LEN_UPDATE = CNT_W'(6);

    // Event kind codes.
    localparam logic [2:0] EV_CONN   = 3'd0;
    localparam logic [2:0] EV_LOST   = 3'd1;
    localparam logic [2:0] EV_TIME   = 3'd2;
    localparam logic [2:0] EV_DATE   = 3'd3;
    localparam logic [2:0] EV_NOTIFY = 3'd4;
    localparam logic [2:0] EV_UPDATE = 3'd5;

    // Buffer contents as they stand after the current word is appended.
    typedef logic [BUFFER_CHARS-1:0][7:0] char_row_t;

    typedef struct packed {
        char_row_t        chars;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] count_now;
    } store_view_t;

    // One decoded event plus the control that goes back to the buffer.
    typedef struct packed {
        logic        hit;
        logic        clear_buf;
        logic [2:0]  kind;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic [63:0] payload;
    } event_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Two-character number; conversion stops at the first non-digit.
    function automatic logic [6:0] two_digits(input logic [7:0] c0, input logic [7:0] c1);
        logic [6:0] v;
        v = '0;
        if (is_digit(c0))
        begin
            v = 7'(c0 - CH_ZERO);
            if (is_digit(c1))
            begin
                v = 7'(v * 7'd10) + 7'(c1 - CH_ZERO);
            end
        end
        return v;
    endfunction

    // Four-character number; conversion stops at the first non-digit.
    function automatic logic [13:0] four_digits(input logic [7:0] c0, input logic [7:0] c1,
                                                input logic [7:0] c2, input logic [7:0] c3);
        logic [13:0] v;
        v = '0;
        if (is_digit(c0))
        begin
            v = 14'(c0 - CH_ZERO);
            if (is_digit(c1))
            begin
                v = 14'(v * 14'd10) + 14'(c1 - CH_ZERO);
                if (is_digit(c2))
                begin
                    v = 14'(v * 14'd10) + 14'(c2 - CH_ZERO);
                    if (is_digit(c3))
                    begin
                        v = 14'(v * 14'd10) + 14'(c3 - CH_ZERO);
                    end
                end
            end
        end
        return v;
    endfunction

endpackage

>>> design/link_command_recognizer.sv
// ============================================================================
// Link command recognizer
// Collects received link characters and reports recognized commands as
// events with their decoded fields.
// ============================================================================
//
//  Channel | Handshake            | Fields
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| event_kind, hours, minutes, seconds,
//          |                      | day_value, month_value, year_value,
//          |                      | notify_payload
//
//  One word per cycle sustained while no held event stalls the input register.
//  A word is registered on entry, then appended to the buffer, compared, and
//  any event loaded into the output register.
//  The asynchronous reset empties the buffer and both word registers.
//  A held event stalls the input register; a word that gives no event moves
//  on even while an event waits at the output.
//
module link_command_recognizer
    import lcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [6:0]  hours,
    output logic [6:0]  minutes,
    output logic [6:0]  seconds,
    output logic [6:0]  day_value,
    output logic [6:0]  month_value,
    output logic [13:0] year_value,
    output logic [63:0] notify_payload
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    event_t      out_evt_reg;
    store_view_t view;
    event_t      evt;
    logic        out_free;
    logic        process_fire;

    // A word moves on when it brings no event or the output can take one.
    always_comb
    begin
        out_free     = !out_valid_reg || out_ready;
        process_fire = in_valid_reg && (out_free || !evt.hit);
        in_ready     = !in_valid_reg || process_fire;
    end

    lcr_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (process_fire),
        .in_byte     (in_byte_reg),
        .clear_after (evt.clear_buf),
        .view        (view)
    );

    lcr_decode u_decode (
        .view    (view),
        .in_byte (in_byte_reg),
        .evt     (evt)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process_fire && evt.hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process_fire && evt.hit)
        begin
            out_evt_reg <= evt;
        end
    end

    // Output ports.
    assign out_valid      = out_valid_reg;
    assign event_kind     = out_evt_reg.kind;
    assign hours          = out_evt_reg.hours;
    assign minutes        = out_evt_reg.minutes;
    assign seconds        = out_evt_reg.seconds;
    assign day_value      = out_evt_reg.day;
    assign month_value    = out_evt_reg.month;
    assign year_value     = out_evt_reg.year;
    assign notify_payload = out_evt_reg.payload;

`ifndef SYNTHESIS
    // The fill count never runs past the buffer size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        view.count_now <= CNT_W'(BUFFER_CHARS))
        else $error("fill count exceeds buffer size");

    // An event never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(process_fire && evt.hit))
        else $error("pending event overwritten");

    // Every event other than update leaves the buffer empty.
    a_clear_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        (process_fire && evt.hit && (evt.kind != EV_UPDATE))
        |=> (view.count_now == '0))
        else $error("buffer not emptied after event");

    // A plus word leaves the buffer empty and gives no event.
    a_plus_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (process_fire && (in_byte_reg == CH_PLUS))
        |=> ((view.count_now == '0) && !$rose(out_valid_reg)))
        else $error("plus word mishandled");
`endif

endmodule

>>> design/lcr_store.sv
// ============================================================================
// Link command recognizer character store
// Holds the command characters and the fill count, and presents the buffer
// as it looks once the current word has been appended.
// ============================================================================
module lcr_store
    import lcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        commit,
    input  logic [7:0]  in_byte,
    input  logic        clear_after,
    output store_view_t view
);

    logic [7:0]       char_store_reg [BUFFER_CHARS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] count_appended;
    logic             is_plus;

    // A full buffer restarts at position zero.
    always_comb
    begin
        if (count_reg >= CNT_W'(BUFFER_CHARS))
        begin
            wr_idx = '0;
        end
        else
        begin
            wr_idx = count_reg[IDX_W-1:0];
        end
        count_appended = CNT_W'(wr_idx) + CNT_W'(1);
        is_plus        = (in_byte == CH_PLUS);
    end

    // Buffer view with the new word already in place.
    always_comb
    begin
        for (int i = 0; i < BUFFER_CHARS; i++)
        begin
            if (IDX_W'(i) == wr_idx)
            begin
                view.chars[i] = in_byte;
            end
            else
            begin
                view.chars[i] = char_store_reg[i];
            end
        end
        view.count     = count_appended;
        view.count_now = count_reg;
    end

    // Fill count update: a plus word or a clearing match empties the buffer.
    always_comb
    begin
        count_next = count_reg;
        if (commit)
        begin
            if (is_plus || clear_after)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_appended;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Character storage needs no reset; only written entries are compared.
    always_ff @(posedge clk)
    begin
        if (commit && !is_plus)
        begin
            char_store_reg[wr_idx] <= in_byte;
        end
    end

endmodule

>>> design/lcr_decode.sv
// ============================================================================
// Link command recognizer decoder
// Compares the buffer view against the known commands and extracts the
// numeric and payload fields of a match.
// ============================================================================
module lcr_decode
    import lcr_pkg::*;
(
    input  store_view_t view,
    input  logic [7:0]  in_byte,
    output event_t      evt
);

    logic       is_plus;
    logic       m_conn;
    logic       m_lost;
    logic       m_time;
    logic       m_date;
    logic       m_notify;
    logic       m_update;
    logic [39:0] prefix5;

    // Command matches, each gated by its exact fill count.
    always_comb
    begin
        is_plus  = (in_byte == CH_PLUS);
        prefix5  = {view.chars[0], view.chars[1], view.chars[2], view.chars[3],
                    view.chars[4]};
        m_conn   = (view.count == LEN_SHORT) && (prefix5[39:8] == CMD_CONN);
        m_lost   = (view.count == LEN_SHORT) && (prefix5[39:8] == CMD_LOST);
        m_time   = (view.count == LEN_TIME) && (prefix5 == CMD_TIME);
        m_date   = (view.count == LEN_DATE) && (prefix5 == CMD_DATE);
        m_notify = (view.count == LEN_NOTIFY) && (prefix5 == CMD_NOTIFY);
        m_update = (view.count == LEN_UPDATE)
                   && ({prefix5, view.chars[5]} == CMD_UPDATE);
    end

    // Priority select of the event and its fields; unused fields stay zero.
    always_comb
    begin
        evt           = '0;
        evt.clear_buf = 1'b1;
        if (!is_plus)
        begin
            if (m_conn)
            begin
                evt.hit  = 1'b1;
                evt.kind = EV_CONN;
            end
            else if (m_lost)
            begin
                evt.hit  = 1'b1;
                evt.kind = EV_LOST;
            end
            else if (m_time)
            begin
                evt.hit     = 1'b1;
                evt.kind    = EV_TIME;
                evt.hours   = two_digits(view.chars[5], view.chars[6]);
                evt.minutes = two_digits(view.chars[7], view.chars[8]);
                evt.seconds = two_digits(view.chars[9], view.chars[10]);
            end
            else if (m_date)
            begin
                evt.hit   = 1'b1;
                evt.kind  = EV_DATE;
                evt.day   = two_digits(view.chars[5], view.chars[6]);
                evt.month = two_digits(view.chars[7], view.chars[8]);
                evt.year  = four_digits(view.chars[9], view.chars[10],
                                        view.chars[11], view.chars[12]);
            end
            else if (m_notify)
            begin
                evt.hit     = 1'b1;
                evt.kind    = EV_NOTIFY;
                evt.payload = {view.chars[12], view.chars[11], view.chars[10],
                               view.chars[9], view.chars[8], view.chars[7],
                               view.chars[6], view.chars[5]};
            end
            else if (m_update)
            begin
                evt.hit       = 1'b1;
                evt.kind      = EV_UPDATE;
                evt.clear_buf = 1'b0;
            end
        end
        if (!evt.hit)
        begin
            evt.clear_buf = 1'b0;
        end
    end

endmodule
